// ===== hdl/mcrwa_pkg.sv =====
package mcrwa_pkg;

    // Default sizes
    localparam int LINES_DEF      = 4;
    localparam int MAX_DELAY_DEF  = 16384;
    localparam int MAX_RADIUS_DEF = 63;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int COMB_W   = 24;
    localparam int GAIN_W   = 16;
    localparam int BASE_W   = 14;
    localparam int RADIUS_W = 6;
    localparam int OFFSET_W = 13;
    localparam int SEEN_W   = 7;
    localparam int RING_AW  = 7;
    localparam int OFFSET_REGS = 4;

    // Mix arithmetic
    localparam int NUM_W = 52;
    localparam int QUO_W = NUM_W - 16;
    localparam logic [16:0] Q15_ONE = 17'd32768;
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LINE0  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LINE1  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LINE2  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LINE3  = 4'd7;

    // Sequencer states
    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_RD     = 14'b00000000000010,
        ST_MUL    = 14'b00000000000100,
        ST_ACC    = 14'b00000000001000,
        ST_FIN    = 14'b00000000010000,
        ST_ESTART = 14'b00000000100000,
        ST_RADDR  = 14'b00000001000000,
        ST_RACC   = 14'b00000010000000,
        ST_M1     = 14'b00000100000000,
        ST_M2     = 14'b00001000000000,
        ST_M3     = 14'b00010000000000,
        ST_DIV    = 14'b00100000000000,
        ST_OUT    = 14'b01000000000000,
        ST_DONE   = 14'b10000000000000
    } state_t;

endpackage

// ===== hdl/mcrwa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle
module mcrwa_div #(
    parameter int N_W = 36,
    parameter int D_W = 10
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [D_W:0]     shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= D_W'(shifted - {1'b0, div_reg});
                quo_reg <= {quo_reg[N_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[D_W-1:0];
                quo_reg <= {quo_reg[N_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/multi_comb_reverb_with_window_average.sv =====
// Per input request: each comb line is read from memory, multiplied and written back
// (states RD, MUL, ACC), then FIN stores the sample; for each result the window entries
// are summed (RADDR, RACC per entry), then M1, M2, M3 and the divider (DIV) run before OUT.
// A final request produces min(seen, r) + 1 results, one after another.
// Reset (aresetn low, synchronous) restores register defaults and clears control;
// unwritten history reads as zero through a wrap flag, so no clearing pass is needed.
module multi_comb_reverb_with_window_average #(
    parameter int LINES      = mcrwa_pkg::LINES_DEF,
    parameter int MAX_DELAY  = mcrwa_pkg::MAX_DELAY_DEF,
    parameter int MAX_RADIUS = mcrwa_pkg::MAX_RADIUS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] in_sample
    input  logic                              s_tlast,   // stream_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] out_sample
    output logic                              m_tlast,   // final_result
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mcrwa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcrwa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW     = $clog2(MAX_DELAY);
    localparam int LW     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int SUM_W  = mcrwa_pkg::COMB_W + $clog2(LINES) + 1;
    localparam int TOT_W  = SUM_W + mcrwa_pkg::SEEN_W;
    localparam int LC_W   = mcrwa_pkg::SEEN_W + $clog2(LINES) + 1;
    localparam int DLY_W  = AW + 2;
    localparam int CDEPTH = LINES * (2 ** AW);
    localparam int SW     = mcrwa_pkg::SAMPLE_W;
    localparam int CW     = mcrwa_pkg::COMB_W;
    localparam int QW     = mcrwa_pkg::QUO_W;
    localparam int NW     = mcrwa_pkg::NUM_W;
    localparam int PW     = mcrwa_pkg::GAIN_W + CW;

    // Configuration registers
    logic [15:0]                      wet_reg;
    logic signed [15:0]               fb_reg;
    logic [mcrwa_pkg::BASE_W-1:0]     base_reg;
    logic [mcrwa_pkg::RADIUS_W-1:0]   radius_reg;
    logic [mcrwa_pkg::OFFSET_W-1:0]   offset_reg [mcrwa_pkg::OFFSET_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_reg       <= 16'd16384;
            fb_reg        <= 16'sd16384;
            base_reg      <= 14'd1000;
            radius_reg    <= 6'd4;
            offset_reg[0] <= 13'd0;
            offset_reg[1] <= 13'd1237;
            offset_reg[2] <= 13'd2591;
            offset_reg[3] <= 13'd3877;
        end else if (cfg_valid) begin
            case (cfg_index)
                mcrwa_pkg::REG_WET_MIX:       wet_reg       <= cfg_data;
                mcrwa_pkg::REG_FEEDBACK_GAIN: fb_reg        <= $signed(cfg_data);
                mcrwa_pkg::REG_BASE_DELAY:    base_reg      <= cfg_data[13:0];
                mcrwa_pkg::REG_WINDOW_RADIUS: radius_reg    <= cfg_data[5:0];
                mcrwa_pkg::REG_OFFSET_LINE0:  offset_reg[0] <= cfg_data[12:0];
                mcrwa_pkg::REG_OFFSET_LINE1:  offset_reg[1] <= cfg_data[12:0];
                mcrwa_pkg::REG_OFFSET_LINE2:  offset_reg[2] <= cfg_data[12:0];
                mcrwa_pkg::REG_OFFSET_LINE3:  offset_reg[3] <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Memories
    logic signed [SW-1:0]    dry_mem  [2 ** AW];
    logic signed [CW-1:0]    comb_mem [CDEPTH];
    logic signed [SUM_W-1:0] ring_mem [2 ** mcrwa_pkg::RING_AW];

    // Control and state
    mcrwa_pkg::state_t state_reg, state_next;
    logic [AW-1:0]                  wp_reg, wp_next;
    logic                           wrap_reg, wrap_next;
    logic [mcrwa_pkg::RING_AW-1:0]  rp_reg, rp_next;
    logic [mcrwa_pkg::SEEN_W-1:0]   seen_reg, seen_next;
    logic [LW-1:0]                  line_reg, line_next;
    logic [5:0]                     r_reg, r_next;
    logic [5:0]                     lag_reg, lag_next;
    logic [mcrwa_pkg::SEEN_W-1:0]   cnt_reg, cnt_next;
    logic [mcrwa_pkg::SEEN_W-1:0]   b_reg, b_next;
    logic                           last_reg, last_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_last_reg, m_last_next;
    logic [15:0]                    m_data_reg, m_data_next;

    // Payload registers
    logic signed [SW-1:0]    x_reg;
    logic signed [SUM_W-1:0] sacc_reg;
    logic signed [TOT_W-1:0] tot_reg;
    logic                    hvalid_reg;
    logic signed [SW-1:0]    dry_rd_reg;
    logic signed [CW-1:0]    comb_rd_reg;
    logic signed [SUM_W-1:0] ring_rd_reg;
    logic signed [SW-1:0]    dold_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [33:0]      pa_reg;
    logic signed [TOT_W+16:0] pb_reg;
    logic signed [34+LC_W:0] pa2_reg;
    logic [LC_W-1:0]         lc_reg;
    logic                    neg_reg;

    // Line delay and history address
    logic [DLY_W-1:0] dsum, dly;
    logic [AW:0]      old_wide;
    logic [AW-1:0]    old_addr;
    logic             old_valid;

    always_comb begin
        dsum = DLY_W'(base_reg) + DLY_W'(offset_reg[2'(line_reg % mcrwa_pkg::OFFSET_REGS)]);
        if (dsum < DLY_W'(1))
            dly = DLY_W'(1);
        else if (dsum > DLY_W'(MAX_DELAY - 1))
            dly = DLY_W'(MAX_DELAY - 1);
        else
            dly = dsum;
        if ((AW + 1)'(wp_reg) >= (AW + 1)'(dly))
            old_wide = (AW + 1)'(wp_reg) - (AW + 1)'(dly);
        else
            old_wide = (AW + 1)'(wp_reg) + (AW + 1)'(MAX_DELAY) - (AW + 1)'(dly);
        old_addr  = old_wide[AW-1:0];
        old_valid = wrap_reg || (old_addr < wp_reg);
    end

    // Dry slot for a result
    logic [AW:0]   slot_wide;
    logic [AW-1:0] slot_addr;

    always_comb begin
        if ((AW + 1)'(wp_reg) >= (AW + 1)'(lag_reg))
            slot_wide = (AW + 1)'(wp_reg) - (AW + 1)'(lag_reg);
        else
            slot_wide = (AW + 1)'(wp_reg) + (AW + 1)'(MAX_DELAY) - (AW + 1)'(lag_reg);
        slot_addr = slot_wide[AW-1:0];
    end

    // Comb update
    logic signed [PW:0]  prod_rnd;
    logic signed [26:0]  comb_sum;
    logic signed [CW-1:0] comb_new;

    always_comb begin
        prod_rnd = (PW + 1)'(prod_reg) + (PW + 1)'(16384);
        comb_sum = 27'(dold_reg) + 27'(prod_rnd >>> 15);
        if (comb_sum > 27'sd8388607)
            comb_new = 24'sd8388607;
        else if (comb_sum < -27'sd8388608)
            comb_new = -24'sd8388608;
        else
            comb_new = comb_sum[CW-1:0];
    end

    // Memory ports
    logic                            dry_re, comb_re, ring_re;
    logic [AW-1:0]                   dry_raddr;
    logic [mcrwa_pkg::RING_AW-1:0]   ring_raddr;

    assign dry_re     = (state_reg == mcrwa_pkg::ST_RD) || (state_reg == mcrwa_pkg::ST_ESTART);
    assign comb_re    = (state_reg == mcrwa_pkg::ST_RD);
    assign ring_re    = (state_reg == mcrwa_pkg::ST_RADDR);
    assign dry_raddr  = (state_reg == mcrwa_pkg::ST_RD) ? old_addr : slot_addr;
    assign ring_raddr = rp_reg - b_reg;

    always_ff @(posedge aclk) begin
        if (dry_re)
            dry_rd_reg <= dry_mem[dry_raddr];
        if (state_reg == mcrwa_pkg::ST_FIN)
            dry_mem[wp_reg] <= x_reg;
    end

    always_ff @(posedge aclk) begin
        if (comb_re)
            comb_rd_reg <= comb_mem[{line_reg, old_addr}];
        if (state_reg == mcrwa_pkg::ST_ACC)
            comb_mem[{line_reg, wp_reg}] <= comb_new;
    end

    always_ff @(posedge aclk) begin
        if (ring_re)
            ring_rd_reg <= ring_mem[ring_raddr];
        if (state_reg == mcrwa_pkg::ST_FIN)
            ring_mem[rp_reg] <= sacc_reg;
    end

    // Mix arithmetic
    logic [15:0]              w_eff;
    logic [16:0]              omw;
    logic [mcrwa_pkg::SEEN_W-1:0] cnt_eff;
    logic signed [TOT_W-1:0]  tot_eff;
    logic signed [NW-1:0]     num, n2;
    logic signed [QW-1:0]     quo_in;
    logic [QW-1:0]            div_mag;
    logic [QW-1:0]            div_q;
    logic signed [QW-1:0]     res;
    logic [15:0]              res_sat;
    logic                     div_start, div_busy, div_done;

    always_comb begin
        w_eff   = (wet_reg > 16'd32768) ? 16'd32768 : wet_reg;
        omw     = mcrwa_pkg::Q15_ONE - 17'(w_eff);
        cnt_eff = (cnt_reg == '0) ? mcrwa_pkg::SEEN_W'(1) : cnt_reg;
        tot_eff = (cnt_reg == '0) ? '0 : tot_reg;
        num     = NW'(pa2_reg) + NW'(pb_reg);
        n2      = (num <<< 1) + $signed(NW'({lc_reg, 15'b0}));
        quo_in  = QW'(n2 >>> 16);
        if (quo_in[QW-1])
            div_mag = QW'(-quo_in) + QW'(lc_reg) - QW'(1);
        else
            div_mag = quo_in;
        res = neg_reg ? -$signed(div_q) : $signed(div_q);
        if (res > QW'(32767))
            res_sat = 16'h7FFF;
        else if (res < -QW'(32768))
            res_sat = 16'h8000;
        else
            res_sat = res[15:0];
    end

    assign div_start = (state_reg == mcrwa_pkg::ST_M3);

    mcrwa_div #(
        .N_W (QW),
        .D_W (LC_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (lc_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Payload datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            mcrwa_pkg::ST_IDLE: begin
                x_reg    <= $signed(s_tdata);
                sacc_reg <= '0;
            end
            mcrwa_pkg::ST_RD: hvalid_reg <= old_valid;
            mcrwa_pkg::ST_MUL: begin
                prod_reg <= PW'(fb_reg) * PW'(hvalid_reg ? comb_rd_reg : CW'(0));
                dold_reg <= hvalid_reg ? dry_rd_reg : SW'(0);
            end
            mcrwa_pkg::ST_ACC: sacc_reg <= sacc_reg + SUM_W'(comb_new);
            mcrwa_pkg::ST_ESTART: tot_reg <= '0;
            mcrwa_pkg::ST_RACC: tot_reg <= tot_reg + TOT_W'(ring_rd_reg);
            mcrwa_pkg::ST_M1: begin
                pa_reg <= 34'(dry_rd_reg) * 34'($signed({1'b0, omw}));
                pb_reg <= (TOT_W + 17)'($signed({1'b0, w_eff})) * (TOT_W + 17)'(tot_eff);
                lc_reg <= LC_W'(LINES) * LC_W'(cnt_eff);
            end
            mcrwa_pkg::ST_M2:
                pa2_reg <= (35 + LC_W)'(pa_reg) * (35 + LC_W)'($signed({1'b0, lc_reg}));
            mcrwa_pkg::ST_M3: neg_reg <= quo_in[QW-1];
            default: ;
        endcase
    end

    // Sequencer
    logic [6:0] lag_sum;
    assign lag_sum = 7'(lag_reg) + 7'(r_reg);

    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        wrap_next    = wrap_reg;
        rp_next      = rp_reg;
        seen_next    = seen_reg;
        line_next    = line_reg;
        r_next       = r_reg;
        lag_next     = lag_reg;
        cnt_next     = cnt_reg;
        b_next       = b_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        m_last_next  = m_last_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            mcrwa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    last_next  = s_tlast;
                    r_next     = (32'(radius_reg) > MAX_RADIUS) ? 6'(MAX_RADIUS) : radius_reg;
                    line_next  = '0;
                    state_next = mcrwa_pkg::ST_RD;
                end
            end
            mcrwa_pkg::ST_RD:  state_next = mcrwa_pkg::ST_MUL;
            mcrwa_pkg::ST_MUL: state_next = mcrwa_pkg::ST_ACC;
            mcrwa_pkg::ST_ACC: begin
                if (32'(line_reg) == LINES - 1) begin
                    state_next = mcrwa_pkg::ST_FIN;
                end else begin
                    line_next  = line_reg + 1'b1;
                    state_next = mcrwa_pkg::ST_RD;
                end
            end
            mcrwa_pkg::ST_FIN: begin
                if (last_reg) begin
                    lag_next   = (seen_reg < 7'(r_reg)) ? 6'(seen_reg) : r_reg;
                    state_next = mcrwa_pkg::ST_ESTART;
                end else if (seen_reg >= 7'(r_reg)) begin
                    lag_next   = r_reg;
                    state_next = mcrwa_pkg::ST_ESTART;
                end else begin
                    state_next = mcrwa_pkg::ST_DONE;
                end
            end
            mcrwa_pkg::ST_ESTART: begin
                cnt_next   = (lag_sum > seen_reg) ? seen_reg : lag_sum;
                b_next     = mcrwa_pkg::SEEN_W'(1);
                state_next = mcrwa_pkg::ST_RADDR;
            end
            mcrwa_pkg::ST_RADDR: begin
                state_next = (b_reg > cnt_reg) ? mcrwa_pkg::ST_M1 : mcrwa_pkg::ST_RACC;
            end
            mcrwa_pkg::ST_RACC: begin
                b_next     = b_reg + 1'b1;
                state_next = mcrwa_pkg::ST_RADDR;
            end
            mcrwa_pkg::ST_M1: state_next = mcrwa_pkg::ST_M2;
            mcrwa_pkg::ST_M2: state_next = mcrwa_pkg::ST_M3;
            mcrwa_pkg::ST_M3: state_next = mcrwa_pkg::ST_DIV;
            mcrwa_pkg::ST_DIV: begin
                if (div_done)
                    state_next = mcrwa_pkg::ST_OUT;
            end
            mcrwa_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_sat;
                    m_last_next  = last_reg && (lag_reg == '0);
                    if (last_reg && (lag_reg != '0)) begin
                        lag_next   = lag_reg - 1'b1;
                        state_next = mcrwa_pkg::ST_ESTART;
                    end else begin
                        state_next = mcrwa_pkg::ST_DONE;
                    end
                end
            end
            mcrwa_pkg::ST_DONE: begin
                if (last_reg)
                    seen_next = '0;
                else if (seen_reg != mcrwa_pkg::SEEN_MAX)
                    seen_next = seen_reg + 1'b1;
                if (32'(wp_reg) == MAX_DELAY - 1) begin
                    wp_next   = '0;
                    wrap_next = 1'b1;
                end else begin
                    wp_next = wp_reg + 1'b1;
                end
                rp_next    = rp_reg + 1'b1;
                state_next = mcrwa_pkg::ST_IDLE;
            end
            default: state_next = mcrwa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mcrwa_pkg::ST_IDLE;
            wp_reg      <= '0;
            wrap_reg    <= 1'b0;
            rp_reg      <= '0;
            seen_reg    <= '0;
            line_reg    <= '0;
            r_reg       <= '0;
            lag_reg     <= '0;
            cnt_reg     <= '0;
            b_reg       <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            wrap_reg    <= wrap_next;
            rp_reg      <= rp_next;
            seen_reg    <= seen_next;
            line_reg    <= line_next;
            r_reg       <= r_next;
            lag_reg     <= lag_next;
            cnt_reg     <= cnt_next;
            b_reg       <= b_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == mcrwa_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mcrwa_pkg::ST_OUT) && m_valid_reg && !m_tready
        |=> (state_reg == mcrwa_pkg::ST_OUT))
        else $error("pending result would be overwritten");

    a_div_idle_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("divider busy while taking a new request");

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mcrwa_pkg::ST_RACC) |-> (b_reg <= cnt_reg) && (cnt_reg <= seen_reg))
        else $error("window read beyond the samples seen");

    a_final_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mcrwa_pkg::ST_OUT) && $past(state_reg == mcrwa_pkg::ST_DIV)
        |-> !last_reg || (lag_reg <= r_reg))
        else $error("flush lag exceeds radius");

endmodule
